@@ rtl/pthc_pkg.sv @@
// pthc_pkg: shared constants, register indexes and width helpers for pixel_to_hex_cell
// no dependencies; compiled first
`default_nettype none

package pthc_pkg;

   localparam int COORD_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int RADIUS_BITS    = 12;
   localparam int OUT_BITS       = 17;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = RADIUS_BITS;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HEX_RADIUS = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ORIENT     = 1'b1;

   localparam logic [RADIUS_BITS-1:0] HEX_RADIUS_RESET = 12'd32;
   localparam logic                   ORIENT_RESET     = 1'b1;

   // sqrt(3) in q.32
   localparam longint unsigned SQRT3_Q32 = 64'd7439101573;

   // sqrt(3) rounded to frac fraction bits
   function automatic longint unsigned sqrt3_fix(input int frac);
      return (SQRT3_Q32 + (64'd1 << (31 - frac))) >> (32 - frac);
   endfunction

   // numerator width, signed
   function automatic int num_bits(input int coord, input int frac);
      return coord + frac + 3;
   endfunction

   // width of 3 * radius * 2^frac
   function automatic int den_bits(input int frac);
      return RADIUS_BITS + 2 + frac;
   endfunction

   // rounded quotient magnitude width
   function automatic int quo_bits(input int coord);
      return coord + 1;
   endfunction

endpackage

`default_nettype wire

@@ rtl/pthc_req_if.sv @@
// pthc_req_if: input channel carrying one pixel coordinate pair per transaction
// depends on pthc_pkg for the default coordinate width
`default_nettype none

interface pthc_req_if #(
   parameter int COORD_BITS = pthc_pkg::COORD_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] pixel_x;
   logic signed [COORD_BITS-1:0] pixel_y;

   modport source (output valid, output pixel_x, output pixel_y, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

`default_nettype wire

@@ rtl/pthc_rsp_if.sv @@
// pthc_rsp_if: result channel carrying one cube coordinate triple per transaction
// depends on pthc_pkg for the output width
`default_nettype none

interface pthc_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [pthc_pkg::OUT_BITS-1:0] cube_q;
   logic signed [pthc_pkg::OUT_BITS-1:0] cube_s;
   logic signed [pthc_pkg::OUT_BITS-1:0] cube_r;

   modport source (output valid, output cube_q, output cube_s, output cube_r, input ready);
   modport sink   (input valid, input cube_q, input cube_s, input cube_r, output ready);
endinterface

`default_nettype wire

@@ rtl/pthc_numer.sv @@
// pthc_numer: two pipeline stages forming the fixed point cube numerators
// depends on pthc_pkg (sqrt3 constant, width helpers)
`default_nettype none

module pthc_numer #(
   parameter int COORD_BITS = pthc_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = pthc_pkg::FRAC_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output      logic                  in_ready,
   input  wire logic signed [COORD_BITS-1:0] pixel_x,
   input  wire logic signed [COORD_BITS-1:0] pixel_y,
   input  wire logic                  flat_sel,
   output      logic                  out_valid,
   input  wire logic                  out_ready,
   output      logic signed [pthc_pkg::num_bits(COORD_BITS, FRAC_BITS)-1:0] num [3]
);
   import pthc_pkg::*;

   localparam int NB = num_bits(COORD_BITS, FRAC_BITS);
   localparam int PW = COORD_BITS + FRAC_BITS + 2;
   localparam logic [FRAC_BITS:0] SQ = (FRAC_BITS + 1)'(sqrt3_fix(FRAC_BITS));

   // stage a: sqrt3 product
   logic                         a_vld_ff;
   logic                         a_rdy;
   logic signed [PW-1:0]         prod_ff, prod_in;
   logic signed [COORD_BITS-1:0] lin_ff, lin_in;
   logic                         flat_ff;

   // stage b: numerators
   logic                         b_vld_ff;
   logic                         b_rdy;
   logic signed [NB-1:0]         num_ff [3];
   logic signed [NB-1:0]         num_in [3];
   logic signed [NB-1:0]         diff, dbl;

   assign b_rdy    = !b_vld_ff || out_ready;
   assign a_rdy    = !a_vld_ff || b_rdy;
   assign in_ready = a_rdy;

   always_comb begin
      // flat-top multiplies y by sqrt3, pointy-top multiplies x
      lin_in  = flat_sel ? pixel_x : pixel_y;
      prod_in = $signed({1'b0, SQ}) * (flat_sel ? pixel_y : pixel_x);
   end

   always_comb begin
      diff = NB'(prod_ff) - (NB'(lin_ff) <<< FRAC_BITS);
      dbl  = NB'(lin_ff) <<< (FRAC_BITS + 1);
      num_in[0] = flat_ff ? dbl : diff;
      num_in[2] = flat_ff ? diff : dbl;
      num_in[1] = -(diff + dbl);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else begin
         if (a_rdy) a_vld_ff <= in_valid;
         if (b_rdy) b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_rdy) begin
         prod_ff <= prod_in;
         lin_ff  <= lin_in;
         flat_ff <= flat_sel;
      end
      if (b_rdy) begin
         num_ff <= num_in;
      end
   end

   assign out_valid = b_vld_ff;
   assign num       = num_ff;

endmodule

`default_nettype wire

@@ rtl/pthc_div.sv @@
// pthc_div: pipelined restoring divider, three lanes, an entry stage then one quotient bit per stage
// depends on pthc_pkg (width helpers)
`default_nettype none

module pthc_div #(
   parameter int COORD_BITS = pthc_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = pthc_pkg::FRAC_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   output      logic in_ready,
   input  wire logic signed [pthc_pkg::num_bits(COORD_BITS, FRAC_BITS)-1:0] num [3],
   input  wire logic [pthc_pkg::den_bits(FRAC_BITS)-1:0] den,
   output      logic out_valid,
   input  wire logic out_ready,
   output      logic [pthc_pkg::quo_bits(COORD_BITS)-1:0] quo [3],
   output      logic [pthc_pkg::den_bits(FRAC_BITS):0]    rem [3],
   output      logic                                      neg [3]
);
   import pthc_pkg::*;

   localparam int NB = num_bits(COORD_BITS, FRAC_BITS);
   localparam int DB = den_bits(FRAC_BITS);
   localparam int QB = quo_bits(COORD_BITS);
   // partial remainder: dividend < 2*den * 2^QB
   localparam int RW = QB + DB + 1;
   localparam int MW = ((NB + 1 > DB) ? NB + 1 : DB) + 1;
   localparam int XW = (MW > RW) ? MW : RW;

   logic [QB:0]       vld_ff;
   logic [QB+1:0]     rdy;
   logic [RW-1:0]     rem_ff [QB+1][3];
   logic [RW-1:0]     rem_in [QB+1][3];
   logic [QB-1:0]     quo_ff [QB+1][3];
   logic [QB-1:0]     quo_in [QB+1][3];
   logic              neg_ff [QB+1][3];
   logic              neg_in [QB+1][3];
   logic [DB+1:0]     d2x;

   // divisor is twice the denominator
   assign d2x = {1'b0, den, 1'b0};

   assign rdy[QB+1] = out_ready;
   for (genvar s = 0; s <= QB; s++) begin : g_rdy
      assign rdy[s] = !vld_ff[s] || rdy[s+1];
   end
   assign in_ready = rdy[0];

   always_comb begin
      logic [NB-1:0] mag;
      logic [XW-1:0] t;
      logic [DB+1:0] hi;
      int            b;
      // entry: dividend 2*|n| + den gives round half away from zero
      for (int l = 0; l < 3; l++) begin
         mag = num[l][NB-1] ? NB'(-num[l]) : NB'(num[l]);
         t   = (XW'(mag) << 1) + XW'(den);
         rem_in[0][l] = t[RW-1:0];
         quo_in[0][l] = '0;
         neg_in[0][l] = num[l][NB-1];
      end
      for (int s = 1; s <= QB; s++) begin
         b = QB - s;
         for (int l = 0; l < 3; l++) begin
            hi = rem_ff[s-1][l][b +: DB+2];
            rem_in[s][l] = rem_ff[s-1][l];
            quo_in[s][l] = quo_ff[s-1][l];
            neg_in[s][l] = neg_ff[s-1][l];
            if (hi >= d2x) begin
               rem_in[s][l][b +: DB+2] = hi - d2x;
               quo_in[s][l][b]         = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (rdy[0]) vld_ff[0] <= in_valid;
         for (int s = 1; s <= QB; s++) begin
            if (rdy[s]) vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s <= QB; s++) begin
         if (rdy[s]) begin
            rem_ff[s] <= rem_in[s];
            quo_ff[s] <= quo_in[s];
            neg_ff[s] <= neg_in[s];
         end
      end
   end

   assign out_valid = vld_ff[QB];
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         quo[l] = quo_ff[QB][l];
         rem[l] = rem_ff[QB][l][DB:0];
         neg[l] = neg_ff[QB][l];
      end
   end

endmodule

`default_nettype wire

@@ rtl/pthc_round.sv @@
// pthc_round: rounding error compare and recompute of the worst component
// depends on pthc_pkg (width helpers, output width)
`default_nettype none

module pthc_round #(
   parameter int COORD_BITS = pthc_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = pthc_pkg::FRAC_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   output      logic in_ready,
   input  wire logic [pthc_pkg::quo_bits(COORD_BITS)-1:0] quo [3],
   input  wire logic [pthc_pkg::den_bits(FRAC_BITS):0]    rem [3],
   input  wire logic                                      neg [3],
   input  wire logic [pthc_pkg::den_bits(FRAC_BITS)-1:0]  den,
   output      logic out_valid,
   input  wire logic out_ready,
   output      logic signed [pthc_pkg::OUT_BITS-1:0] cube_q,
   output      logic signed [pthc_pkg::OUT_BITS-1:0] cube_s,
   output      logic signed [pthc_pkg::OUT_BITS-1:0] cube_r
);
   import pthc_pkg::*;

   localparam int DB = den_bits(FRAC_BITS);
   localparam int QB = quo_bits(COORD_BITS);
   localparam int EW = (COORD_BITS + 3 > OUT_BITS) ? COORD_BITS + 3 : OUT_BITS;

   logic                 e_vld_ff, e_rdy;
   logic signed [EW-1:0] val_ff [3];
   logic signed [EW-1:0] val_in [3];
   logic [DB:0]          err_ff [3];
   logic [DB:0]          err_in [3];

   logic                 o_vld_ff, o_rdy;
   logic signed [OUT_BITS-1:0] q_ff, s_ff, r_ff;
   logic signed [EW-1:0] q_in, s_in, r_in;
   logic                 fix_q, fix_s;

   assign o_rdy    = !o_vld_ff || out_ready;
   assign e_rdy    = !e_vld_ff || o_rdy;
   assign in_ready = e_rdy;

   // twice the rounding error is |den - remainder|
   always_comb begin
      logic signed [DB+1:0] d;
      logic signed [EW-1:0] m;
      for (int l = 0; l < 3; l++) begin
         d = $signed({2'b00, den}) - $signed({1'b0, rem[l]});
         err_in[l] = d[DB+1] ? (DB + 1)'(-d) : (DB + 1)'(d);
         m = $signed({{(EW - QB){1'b0}}, quo[l]});
         val_in[l] = neg[l] ? -m : m;
      end
   end

   // lanes: 0 = q, 1 = s, 2 = r; q is fixed only when strictly worst, a tie of s and r falls to r
   always_comb begin
      fix_q = (err_ff[0] > err_ff[1]) && (err_ff[0] > err_ff[2]);
      fix_s = !fix_q && (err_ff[1] > err_ff[2]);
      q_in  = fix_q ? -val_ff[1] - val_ff[2] : val_ff[0];
      s_in  = fix_s ? -val_ff[0] - val_ff[2] : val_ff[1];
      r_in  = (!fix_q && !fix_s) ? -val_ff[0] - val_ff[1] : val_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
         o_vld_ff <= 1'b0;
      end else begin
         if (e_rdy) e_vld_ff <= in_valid;
         if (o_rdy) o_vld_ff <= e_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (e_rdy) begin
         val_ff <= val_in;
         err_ff <= err_in;
      end
      if (o_rdy) begin
         q_ff <= q_in[OUT_BITS-1:0];
         s_ff <= s_in[OUT_BITS-1:0];
         r_ff <= r_in[OUT_BITS-1:0];
      end
   end

   assign out_valid = o_vld_ff;
   assign cube_q    = q_ff;
   assign cube_s    = s_ff;
   assign cube_r    = r_ff;

endmodule

`default_nettype wire

@@ rtl/pixel_to_hex_cell.sv @@
// pixel_to_hex_cell: top level, pixel position to hex cell in cube coordinates
// depends on pthc_pkg, pthc_req_if, pthc_rsp_if, pthc_numer, pthc_div, pthc_round
//
// usage
//  - req_bus takes one transaction per pixel (pixel_x, pixel_y, signed);
//    rsp_bus returns one transaction per pixel (cube_q, cube_s, cube_r),
//    in order, with cube_q + cube_s + cube_r == 0
//  - csr_we/csr_index/csr_wdata write hex_radius (index 0, 0 acts as 1)
//    and the orientation (index 1, 1 = flat-top); write only while
//    nothing is in flight
//  - the pipe from req to rsp holds 2 numerator stages, COORD_BITS + 2
//    divider stages (an entry stage, then one quotient bit per stage,
//    three lanes in parallel) and 2 round stages
//  - throughput is one transaction per cycle unless rsp_bus stalls; every
//    stage holds a valid bit and loads when empty or when the stage after it moves
//  - a stall on rsp_bus backs up stage by stage; bubbles are squeezed out,
//    nothing is dropped or repeated, req_bus.ready falls only when full
//  - synchronous reset empties the pipe and loads hex_radius = 32 and
//    the flat-top orientation
`default_nettype none

module pixel_to_hex_cell #(
   parameter int COORD_BITS = pthc_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = pthc_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   pthc_req_if.sink                                    req_bus,
   pthc_rsp_if.source                                  rsp_bus,
   input  wire logic                                   csr_we,
   input  wire logic [pthc_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [pthc_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);
   import pthc_pkg::*;

   localparam int NB = num_bits(COORD_BITS, FRAC_BITS);
   localparam int DB = den_bits(FRAC_BITS);
   localparam int QB = quo_bits(COORD_BITS);

   // configuration registers
   logic [RADIUS_BITS-1:0] radius_ff;
   logic                   flat_ff;
   logic [RADIUS_BITS-1:0] radius_eff;
   logic [RADIUS_BITS+1:0] rad3;
   logic [DB-1:0]          den_ff, den_in;

   // numerator -> divider
   logic                   n_vld, n_rdy;
   logic signed [NB-1:0]   num [3];

   // divider -> round
   logic                   d_vld, d_rdy;
   logic [QB-1:0]          quo [3];
   logic [DB:0]            rem [3];
   logic                   neg [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= HEX_RADIUS_RESET;
         flat_ff   <= ORIENT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_HEX_RADIUS: radius_ff <= csr_wdata;
            CSR_ORIENT:     flat_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // denominator 3 * radius * 2^frac, registered in den_ff behind the radius register;
   // it is first used by the divider entry, two stages in
   always_comb begin
      radius_eff = (radius_ff == '0) ? RADIUS_BITS'(1) : radius_ff;
      rad3       = {radius_eff, 1'b0} + {2'b00, radius_eff};
      den_in     = {rad3, {FRAC_BITS{1'b0}}};
   end

   always_ff @(posedge clock) begin
      den_ff <= den_in;
   end

   pthc_numer #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_numer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .pixel_x   (req_bus.pixel_x),
      .pixel_y   (req_bus.pixel_y),
      .flat_sel  (flat_ff),
      .out_valid (n_vld),
      .out_ready (n_rdy),
      .num       (num)
   );

   pthc_div #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (n_vld),
      .in_ready  (n_rdy),
      .num       (num),
      .den       (den_ff),
      .out_valid (d_vld),
      .out_ready (d_rdy),
      .quo       (quo),
      .rem       (rem),
      .neg       (neg)
   );

   // last round stage is the output register of rsp_bus
   pthc_round #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_round (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_vld),
      .in_ready  (d_rdy),
      .quo       (quo),
      .rem       (rem),
      .neg       (neg),
      .den       (den_ff),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .cube_q    (rsp_bus.cube_q),
      .cube_s    (rsp_bus.cube_s),
      .cube_r    (rsp_bus.cube_r)
   );

endmodule

`default_nettype wire
